// ===== design/msc_pkg.sv =====
// Shared types, widths, register map and helpers for the motor speed calibration sequencer.
package msc_pkg;

  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned FIX_W   = 32;

  localparam int unsigned DIV_NW = 52;
  localparam int unsigned DIV_DW = 16;
  localparam int unsigned DIV_CW = $clog2(DIV_NW);
  localparam int unsigned NUM_W  = DIV_NW + 1;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned APB_W      = 32;

  localparam logic [1:0] REG_DUTY1  = 2'd0;
  localparam logic [1:0] REG_DUTY2  = 2'd1;
  localparam logic [1:0] REG_DUTY3  = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  localparam logic KIND_START = 1'b0;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [3:0]              pad;
    logic signed [FIX_W-1:0] intercept;
    logic signed [FIX_W-1:0] slope;
    logic                    busy;
    logic                    fault;
    logic                    done;
    logic                    wr;
    logic [DUTY_W-1:0]       duty;
  } res_t;

  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [NUM_W-1:0] v);
    logic hi_same;
    hi_same = (&v[NUM_W-1:FIX_W-1]) | ~(|v[NUM_W-1:FIX_W-1]);
    if (hi_same) begin
      return v[FIX_W-1:0];
    end else if (v[NUM_W-1]) begin
      return {1'b1, {(FIX_W-1){1'b0}}};
    end else begin
      return {1'b0, {(FIX_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/msc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module msc_div
  import msc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              done_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[DIV_NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== design/motor_speed_calibration_sequencer.sv =====
// Top level: calibration sequencer with APB registers, stream ports and line fit.
//
//  channel   | signals                                 | role
//  ----------+-----------------------------------------+----------------------------
//  s_axis    | tvalid tready tdata[47:0] tuser[0]      | start / tick request in
//  m_axis    | tvalid tready tdata[87:0]               | one result per request
//  apb       | psel penable pwrite paddr pwdata prdata | duty levels, step period
//
//  Start, tick and fault-fit requests: the result is registered and valid in the cycle after the request.
//  The fitting tick runs five passes of the shared divider (launch, 52 quotient bits,
//  handoff), with a multiply step before the last pass, then an output step.
//  Reset restores register defaults, idle phase and zeroed captures and fit results.
//  A request is taken only when the sequencer is idle and the output register is free
//  or being emptied in the same cycle; a stalled output holds the next request.
module motor_speed_calibration_sequencer
  import msc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] time_now, [47:32] speed_rpm
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] duty_value, [16] duty_write, [17] done_res, [18] fault, [19] busy_res,
  // [51:20] slope, [83:52] intercept, [87:84] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_STEP1 = 3'd2;
  localparam logic [2:0] PH_STEP2 = 3'd3;
  localparam logic [2:0] PH_STEP3 = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_GO   = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT = 3'd2;
  localparam logic [2:0] ST_MUL      = 3'd3;
  localparam logic [2:0] ST_OUT      = 3'd4;

  localparam logic [2:0] FS_Q0   = 3'd0;
  localparam logic [2:0] FS_Q1   = 3'd1;
  localparam logic [2:0] FS_Q2   = 3'd2;
  localparam logic [2:0] FS_M32  = 3'd3;
  localparam logic [2:0] FS_ICPT = 3'd4;

  localparam int unsigned DIFF_W = SPEED_W + 1;
  localparam int unsigned DEN_W  = DUTY_W + 2;
  localparam int unsigned SUM_W  = DUTY_W + 2;
  localparam int unsigned M16_W  = 36;
  localparam int unsigned PROD_W = M16_W + SUM_W + 1;
  localparam logic signed [DEN_W-1:0] DEN_THREE = DEN_W'(3);

  // configuration
  logic [DUTY_W-1:0] duty1_q, duty2_q, duty3_q;
  logic [TIME_W-1:0] period_q;
  logic              cfg_wr;

  // sequence state
  logic [2:0]              phase_q, phase_d;
  logic [TIME_W-1:0]       start_time_q;
  logic [SPEED_W-1:0]      spd_q [3];
  logic signed [FIX_W-1:0] slope_q, icpt_q;

  // fit sequencer
  logic [2:0]              state_q, fit_sel_q;
  logic                    neg_q;
  logic signed [NUM_W-1:0] sum_q;
  logic signed [M16_W-1:0] m16_q;
  logic signed [PROD_W-1:0] prod_q;

  // output register
  logic m_valid_q;
  res_t m_data_q;

  // request decode
  logic               in_acc, in_kind, elapsed, duty_eq, go_fit, fit_fault, record_time;
  logic [2:0]         cap_en;
  logic [TIME_W-1:0]  in_now;
  logic [SPEED_W-1:0] in_speed;
  res_t               res_now, res_fit;
  logic               out_free, out_load;

  // divider operands
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic signed [DIFF_W-1:0] ds0, ds1, ds2, ds_sel;
  logic signed [DEN_W-1:0]  dd0, dd1, dd2, den_sel;
  logic signed [NUM_W-1:0]  num_sel;
  logic [NUM_W-1:0]         num_mag;
  logic [DEN_W-1:0]         den_mag;
  logic [SUM_W-1:0]         ssum, dsum;
  logic signed [PROD_W-1:0] icpt_num, prod_d;
  logic signed [NUM_W-1:0]  q_pos, q_s;
  logic [DIV_NW:0]          m16_rnd;
  logic signed [M16_W-1:0]  m16_d;

  assign in_now   = s_axis_tdata[TIME_W-1:0];
  assign in_speed = s_axis_tdata[TIME_W+SPEED_W-1:TIME_W];
  assign in_kind  = s_axis_tuser;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = ((state_q == ST_IDLE) && in_acc && !go_fit)
                      || ((state_q == ST_OUT) && out_free);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_DUTY1:  prdata = APB_W'(duty1_q);
      REG_DUTY2:  prdata = APB_W'(duty2_q);
      REG_DUTY3:  prdata = APB_W'(duty3_q);
      REG_PERIOD: prdata = period_q;
      default:    prdata = '0;
    endcase
  end

  assign elapsed = (in_now - start_time_q) >= period_q;
  assign duty_eq = (duty1_q == duty2_q) || (duty2_q == duty3_q) || (duty1_q == duty3_q);

  always_comb begin
    phase_d     = phase_q;
    record_time = 1'b0;
    cap_en      = 3'b000;
    go_fit      = 1'b0;
    fit_fault   = 1'b0;
    res_now     = '0;
    res_now.slope     = slope_q;
    res_now.intercept = icpt_q;
    if (in_kind == KIND_START) begin
      phase_d = PH_START;
    end else begin
      case (phase_q)
        PH_START: begin
          record_time  = 1'b1;
          res_now.duty = duty1_q;
          res_now.wr   = 1'b1;
          phase_d      = PH_STEP1;
        end
        PH_STEP1: begin
          if (elapsed) begin
            record_time  = 1'b1;
            cap_en[0]    = 1'b1;
            res_now.duty = duty2_q;
            res_now.wr   = 1'b1;
            phase_d      = PH_STEP2;
          end
        end
        PH_STEP2: begin
          if (elapsed) begin
            record_time  = 1'b1;
            cap_en[1]    = 1'b1;
            res_now.duty = duty3_q;
            res_now.wr   = 1'b1;
            phase_d      = PH_STEP3;
          end
        end
        PH_STEP3: begin
          if (elapsed) begin
            cap_en[2]  = 1'b1;
            res_now.wr = 1'b1;
            phase_d    = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_d = PH_IDLE;
          if (duty_eq) begin
            fit_fault         = 1'b1;
            res_now.done      = 1'b1;
            res_now.fault     = 1'b1;
            res_now.slope     = '0;
            res_now.intercept = '0;
          end else begin
            go_fit = 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    res_now.busy = phase_d != PH_IDLE;
  end

  always_comb begin
    res_fit           = '0;
    res_fit.done      = 1'b1;
    res_fit.slope     = slope_q;
    res_fit.intercept = icpt_q;
  end

  // divider operand selection
  assign ds0 = $signed({1'b0, spd_q[1]}) - $signed({1'b0, spd_q[0]});
  assign ds1 = $signed({1'b0, spd_q[2]}) - $signed({1'b0, spd_q[1]});
  assign ds2 = $signed({1'b0, spd_q[2]}) - $signed({1'b0, spd_q[0]});
  assign dd0 = $signed({2'b00, duty2_q}) - $signed({2'b00, duty1_q});
  assign dd1 = $signed({2'b00, duty3_q}) - $signed({2'b00, duty2_q});
  assign dd2 = $signed({2'b00, duty3_q}) - $signed({2'b00, duty1_q});

  assign ssum = SUM_W'(spd_q[0]) + SUM_W'(spd_q[1]) + SUM_W'(spd_q[2]);
  assign dsum = SUM_W'(duty1_q) + SUM_W'(duty2_q) + SUM_W'(duty3_q);
  assign icpt_num = $signed({{(PROD_W-SUM_W-16){1'b0}}, ssum, 16'h0000}) - prod_q;
  assign prod_d   = m16_q * $signed({1'b0, dsum});

  always_comb begin
    case (fit_sel_q)
      FS_Q0:   begin ds_sel = ds0; den_sel = dd0; end
      FS_Q1:   begin ds_sel = ds1; den_sel = dd1; end
      default: begin ds_sel = ds2; den_sel = dd2; end
    endcase
    case (fit_sel_q)
      FS_M32: begin
        num_sel = sum_q;
        den_sel = DEN_THREE;
      end
      FS_ICPT: begin
        num_sel = icpt_num[NUM_W-1:0];
        den_sel = DEN_THREE;
      end
      default: num_sel = {{(NUM_W-DIFF_W-32){ds_sel[DIFF_W-1]}}, ds_sel, 32'h0};
    endcase
  end

  assign num_mag = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
  assign den_mag = den_sel[DEN_W-1] ? DEN_W'(-den_sel) : DEN_W'(den_sel);

  assign div_req.start    = state_q == ST_DIV_GO;
  assign div_req.dividend = num_mag[DIV_NW-1:0]
                          + {{(DIV_NW-DIV_DW+1){1'b0}}, den_mag[DIV_DW-1:1]};
  assign div_req.divisor  = den_mag[DIV_DW-1:0];

  msc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign q_pos   = $signed({1'b0, div_rsp.quotient});
  assign q_s     = neg_q ? -q_pos : q_pos;
  assign m16_rnd = {1'b0, div_rsp.quotient} + (DIV_NW+1)'(32768);
  assign m16_d   = neg_q ? -$signed({1'b0, m16_rnd[M16_W+14:16]})
                         :  $signed({1'b0, m16_rnd[M16_W+14:16]});

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty1_q      <= DUTY_W'(16384);
      duty2_q      <= DUTY_W'(32768);
      duty3_q      <= DUTY_W'(49152);
      period_q     <= TIME_W'(1000);
      phase_q      <= PH_IDLE;
      start_time_q <= '0;
      spd_q[0]     <= '0;
      spd_q[1]     <= '0;
      spd_q[2]     <= '0;
      slope_q      <= '0;
      icpt_q       <= '0;
      state_q      <= ST_IDLE;
      fit_sel_q    <= FS_Q0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_DUTY1:  duty1_q  <= pwdata[DUTY_W-1:0];
          REG_DUTY2:  duty2_q  <= pwdata[DUTY_W-1:0];
          REG_DUTY3:  duty3_q  <= pwdata[DUTY_W-1:0];
          REG_PERIOD: period_q <= pwdata[TIME_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            phase_q <= phase_d;
            if (record_time) start_time_q <= in_now;
            if (cap_en[0]) spd_q[0] <= in_speed;
            if (cap_en[1]) spd_q[1] <= in_speed;
            if (cap_en[2]) spd_q[2] <= in_speed;
            if (fit_fault) begin
              slope_q <= '0;
              icpt_q  <= '0;
            end
            if (go_fit) begin
              fit_sel_q <= FS_Q0;
              state_q   <= ST_DIV_GO;
            end
          end
        end
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            case (fit_sel_q)
              FS_Q0, FS_Q1, FS_Q2: begin
                fit_sel_q <= fit_sel_q + 3'd1;
                state_q   <= ST_DIV_GO;
              end
              FS_M32: begin
                slope_q <= sat_fix({{(NUM_W-M16_W){m16_d[M16_W-1]}}, m16_d});
                state_q <= ST_MUL;
              end
              default: begin
                icpt_q  <= sat_fix(q_s);
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_MUL: begin
          fit_sel_q <= FS_ICPT;
          state_q   <= ST_DIV_GO;
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      sum_q    <= '0;
      m_data_q <= res_now;
    end
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= res_fit;
    end
    if (state_q == ST_DIV_GO) begin
      neg_q <= num_sel[NUM_W-1] ^ den_sel[DEN_W-1];
    end
    if (state_q == ST_DIV_WAIT && div_rsp.done) begin
      if (fit_sel_q == FS_Q0 || fit_sel_q == FS_Q1 || fit_sel_q == FS_Q2) begin
        sum_q <= sum_q + q_s;
      end
      if (fit_sel_q == FS_M32) begin
        m16_q <= m16_d;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside the wait state");

  a_simple_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !go_fit) |=> m_axis_tvalid)
    else $error("result missing after a one-cycle request");

  a_fault_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_data_q.fault || m_data_q.done))
    else $error("fault flagged without a fit");

  a_fit_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && go_fit) |=> (!s_axis_tready && phase_q == PH_IDLE))
    else $error("request taken while the fit runs");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the calibration sequencer: bursty stimulus, line-fit predictor, checks.
`timescale 1ns / 1ps

module tb_top
  import msc_pkg::*;
();

  localparam logic KIND_TICK   = ~KIND_START;
  localparam int   STALL_LIMIT = 20000;
  localparam int   DRAIN_WAIT  = 400;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_STEP1, PH_STEP2, PH_STEP3, PH_FIT
  } cal_phase_e;

  typedef struct {
    logic        kind;
    logic [31:0] stamp;
    logic [15:0] rpm;
  } tick_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = KIND_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [APB_W-1:0]      pwdata = '0;
  logic [APB_W-1:0]      prdata;
  logic                  pready;

  motor_speed_calibration_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0]        cfg_duty1 = 16'd16384;
  logic [15:0]        cfg_duty2 = 16'd32768;
  logic [15:0]        cfg_duty3 = 16'd49152;
  logic [31:0]        cfg_period = 32'd1000;
  cal_phase_e         cal_phase = PH_IDLE;
  logic [31:0]        cal_start = '0;
  logic [15:0]        cal_rpm [3] = '{16'd0, 16'd0, 16'd0};
  logic signed [31:0] fit_slope = '0;
  logic signed [31:0] fit_icpt = '0;

  tick_req_t pending_reqs [$];
  res_t      due_results [$];
  int        queued_reqs = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;

  function automatic longint rnd_div(input longint n, input longint d);
    logic            neg;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    q   = (un + ud / 2) / ud;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // return 1 when two duty levels coincide
  function automatic logic calib_fit();
    longint d1, d2, d3, s0, s1, s2, q0, q1, q2, m32, m16;
    d1 = cfg_duty1;
    d2 = cfg_duty2;
    d3 = cfg_duty3;
    s0 = cal_rpm[0];
    s1 = cal_rpm[1];
    s2 = cal_rpm[2];
    if (d1 == d2 || d2 == d3 || d1 == d3) begin
      fit_slope = '0;
      fit_icpt  = '0;
      return 1'b1;
    end
    q0  = rnd_div((s1 - s0) * 64'sd4294967296, d2 - d1);
    q1  = rnd_div((s2 - s1) * 64'sd4294967296, d3 - d2);
    q2  = rnd_div((s2 - s0) * 64'sd4294967296, d3 - d1);
    m32 = rnd_div(q0 + q1 + q2, 3);
    m16 = rnd_div(m32, 65536);
    fit_slope = clamp_q16(m16);
    fit_icpt  = clamp_q16(rnd_div((s0 + s1 + s2) * 65536 - m16 * (d1 + d2 + d3), 3));
    return 1'b0;
  endfunction

  function automatic res_t calib_step(input logic kind, input logic [31:0] stamp,
                                     input logic [15:0] rpm);
    res_t r;
    logic elapsed;
    r = '0;
    elapsed = (stamp - cal_start) >= cfg_period;
    if (kind == KIND_START) begin
      cal_phase = PH_START;
    end else begin
      case (cal_phase)
        PH_START: begin
          cal_start = stamp;
          r.duty    = cfg_duty1;
          r.wr      = 1'b1;
          cal_phase = PH_STEP1;
        end
        PH_STEP1: begin
          if (elapsed) begin
            cal_start  = stamp;
            cal_rpm[0] = rpm;
            r.duty     = cfg_duty2;
            r.wr       = 1'b1;
            cal_phase  = PH_STEP2;
          end
        end
        PH_STEP2: begin
          if (elapsed) begin
            cal_start  = stamp;
            cal_rpm[1] = rpm;
            r.duty     = cfg_duty3;
            r.wr       = 1'b1;
            cal_phase  = PH_STEP3;
          end
        end
        PH_STEP3: begin
          if (elapsed) begin
            cal_rpm[2] = rpm;
            r.wr       = 1'b1;
            cal_phase  = PH_FIT;
          end
        end
        PH_FIT: begin
          r.fault   = calib_fit();
          r.done    = 1'b1;
          cal_phase = PH_IDLE;
        end
        default: begin
          cal_phase = PH_IDLE;
        end
      endcase
    end
    r.busy      = cal_phase != PH_IDLE;
    r.slope     = fit_slope;
    r.intercept = fit_icpt;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d at %0t: %s expected %0d got %0d", mismatches, $realtime, what,
               want, got);
    end
  endtask

  // sender: bursts of random length, random gaps between them
  tick_req_t req_now;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(calib_step(s_axis_tuser, s_axis_tdata[31:0],
                                         s_axis_tdata[47:32]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 || pending_reqs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          req_now = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {req_now.rpm, req_now.stamp};
          s_axis_tuser  <= req_now.kind;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall pattern switches each time the 7-bit stall counter wraps
  logic [6:0] stall_tick = '0;
  logic [1:0] stall_mode = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_tick    <= '0;
      stall_mode    <= '0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == '0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= 1'($urandom % 2);
        2'd2: m_axis_tready <= stall_tick[2:0] == 3'd0;
        default: m_axis_tready <= stall_tick[4:3] != 2'd0;
      endcase
    end
  end

  res_t got_res;
  res_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = res_t'(m_axis_tdata);
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result, duty_value", 0, got_res.duty);
      end else begin
        want_res = due_results.pop_front();
        if (got_res.duty != want_res.duty)
          note_mismatch("duty_value", want_res.duty, got_res.duty);
        if (got_res.wr != want_res.wr)
          note_mismatch("duty_write", want_res.wr, got_res.wr);
        if (got_res.done != want_res.done)
          note_mismatch("done_res", want_res.done, got_res.done);
        if (got_res.fault != want_res.fault)
          note_mismatch("fault", want_res.fault, got_res.fault);
        if (got_res.busy != want_res.busy)
          note_mismatch("busy_res", want_res.busy, got_res.busy);
        if (got_res.slope != want_res.slope)
          note_mismatch("slope", want_res.slope, got_res.slope);
        if (got_res.intercept != want_res.intercept)
          note_mismatch("intercept", want_res.intercept, got_res.intercept);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL motor_speed_calibration_sequencer");
      $finish;
    end
  end

  task automatic push_req(input logic kind, input logic [31:0] stamp, input logic [15:0] rpm);
    tick_req_t r;
    r.kind  = kind;
    r.stamp = stamp;
    r.rpm   = rpm;
    pending_reqs.push_back(r);
    queued_reqs++;
  endtask

  function automatic logic [15:0] rand_rpm();
    case ($urandom % 8)
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DUTY1: cfg_duty1 = val[15:0];
      REG_DUTY2: cfg_duty2 = val[15:0];
      REG_DUTY3: cfg_duty3 = val[15:0];
      default:   cfg_period = val;
    endcase
  endtask

  task automatic set_config(input logic [15:0] d1, input logic [15:0] d2,
                            input logic [15:0] d3, input logic [31:0] period);
    reg_write(REG_DUTY1, {16'd0, d1});
    reg_write(REG_DUTY2, {16'd0, d2});
    reg_write(REG_DUTY3, {16'd0, d3});
    reg_write(REG_PERIOD, period);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  // start, then ticks through the given number of steps; a full run ends with the fit tick
  task automatic queue_sequence(input int steps, input logic [15:0] rpm0,
                                input logic [15:0] rpm1, input logic [15:0] rpm2,
                                input int max_waits);
    logic [31:0] t0;
    logic [31:0] extra_cap;
    logic [15:0] rpm [3];
    rpm = '{rpm0, rpm1, rpm2};
    push_req(KIND_START, $urandom, 16'($urandom));
    t0 = ($urandom % 4 == 0) ? 32'hFFFFFFFF - $urandom_range(0, 3000) : $urandom;
    push_req(KIND_TICK, t0, 16'($urandom));
    for (int k = 0; k < steps; k++) begin
      if (cfg_period != 0) begin
        repeat ($urandom_range(0, max_waits)) begin
          push_req(KIND_TICK,
                   t0 + (($urandom % 3 == 0) ? cfg_period - 1 : $urandom_range(0, cfg_period - 1)),
                   rand_rpm());
        end
      end
      extra_cap = ~cfg_period;
      if (extra_cap > 500) extra_cap = 500;
      t0 = t0 + cfg_period + (($urandom % 2 == 0) ? 0 : $urandom_range(0, extra_cap));
      push_req(KIND_TICK, t0, rpm[k]);
    end
    if (steps == 3) push_req(KIND_TICK, $urandom, 16'($urandom));
  endtask

  initial begin
    logic [15:0] d1, d2, d3;
    logic [31:0] period;
    int          target;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: idle tick, short wait, restart mid-run, wrapped time
    push_req(KIND_TICK, 32'hFFFFFFFF, 16'hFFFF);
    push_req(KIND_START, 32'd0, 16'd0);
    push_req(KIND_TICK, 32'd100, 16'h8000);
    push_req(KIND_TICK, 32'd1099, 16'h1234);
    push_req(KIND_TICK, 32'd1100, 16'd0);
    push_req(KIND_START, 32'd5, 16'd5);
    push_req(KIND_TICK, 32'hFFFFFF00, 16'd1);
    push_req(KIND_TICK, 32'h000002E8, 16'd0);
    push_req(KIND_TICK, 32'h000006D0, 16'hFFFF);
    push_req(KIND_TICK, 32'h00000AB8, 16'hFFFF);
    push_req(KIND_TICK, 32'd0, 16'd0);
    wait_drained();

    // top duty levels, zero period: drive the intercept into both rails
    set_config(16'd65533, 16'd65534, 16'd65535, 32'd0);
    queue_sequence(3, 16'h0000, 16'hFFFF, 16'hFFFF, 0);
    queue_sequence(3, 16'hFFFF, 16'h0000, 16'h0000, 0);
    wait_drained();

    // coinciding levels, longest period
    set_config(16'd0, 16'd0, 16'd65535, 32'hFFFFFFFF);
    queue_sequence(3, 16'd1, 16'd2, 16'd3, 1);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      d1 = 16'($urandom);
      d2 = 16'($urandom);
      d3 = 16'($urandom);
      case ($urandom % 8)
        0: d2 = d1;
        1: d3 = d2;
        2: d3 = d1;
        3: begin
          d2 = d1 + 16'd1;
          d3 = d1 + 16'd2;
        end
        default: ;
      endcase
      case ($urandom % 4)
        0: period = $urandom_range(1, 20);
        1: period = $urandom;
        2: period = 32'hFFFFFFFF - $urandom_range(0, 10);
        default: period = $urandom_range(1, 5000);
      endcase
      set_config(d1, d2, d3, period);
      target = queued_reqs + 250;
      while (queued_reqs < target) begin
        case ($urandom % 10)
          7: queue_sequence($urandom_range(0, 2), rand_rpm(), rand_rpm(), rand_rpm(), 3);
          8: push_req(1'($urandom), $urandom, 16'($urandom));
          9: push_req(KIND_TICK, $urandom, rand_rpm());
          default: queue_sequence(3, rand_rpm(), rand_rpm(), rand_rpm(), 3);
        endcase
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("PASS motor_speed_calibration_sequencer");
    end else begin
      $display("FAIL motor_speed_calibration_sequencer");
    end
    $finish;
  end

endmodule
